// ===== hw/rtl/ife_pkg.sv =====
package ife_pkg;

   // configuration register map (word index)
   localparam int unsigned CSR_ADDR_WIDTH   = 3;
   localparam int unsigned CSR_DATA_WIDTH   = 32;
   localparam logic        REG_HEADER_LENGTH = 1'b0;

   localparam logic [4:0] HEADER_LENGTH_RESET = 5'd12;

   localparam logic [4:0] MTI_LAST_POS    = 5'd3;
   localparam logic [4:0] BITMAP_LAST_POS = 5'd15;

   // fixed-length data elements, in ascending field order
   localparam int unsigned NUM_FIELDS = 10;
   localparam int unsigned SLOT_WIDTH = 4;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_MTI    = 3'd1,
      PH_BITMAP = 3'd2,
      PH_FIELD  = 3'd3,
      PH_TRAIL  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       start_of_message;
   } req_type;

   typedef struct packed {
      logic [2:0]  section;
      logic [6:0]  field_number;
      logic [7:0]  data_char;
      logic        section_last;
      logic [63:0] bitmap_value;
      logic        bitmap_valid;
      logic        hex_error;
   } rsp_type;

   // parser state carried from one word to the next
   typedef struct packed {
      phase_type               phase;
      logic [4:0]              pos;
      logic [NUM_FIELDS-1:0]   pending;
      logic [63:0]             bitmap;
      logic [4:0]              high_nibble;
      logic [SLOT_WIDTH-1:0]   slot;
      logic                    done;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_HEADER,
      pos:         5'd0,
      pending:     '0,
      bitmap:      64'd0,
      high_nibble: 5'd0,
      slot:        '0,
      done:        1'b0
   };

endpackage

// ===== hw/rtl/iso8583_field_extractor.sv =====
// channel   direction  handshake                  word
// req       in         req_valid / req_stall      ife_pkg::req_type (char_in, start_of_message)
// rsp       out        rsp_valid / rsp_stall      ife_pkg::rsp_type (one tag word per char)
// csr       in/out     psel penable pwrite pready header_length at byte address 0
//
// one character per clock unless req_stall: the tag is worked out in a single pass from the
// parser state registers and lands in the output register or its skid entry the next edge
// req_stall rises only when both the output register and its skid entry
// hold words, so two words can wait on a stalled rsp side
// reset is synchronous: parser starts in the header, header_length = 12
module iso8583_field_extractor (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ife_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ife_pkg::rsp_type                      rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ife_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  logic [ife_pkg::CSR_DATA_WIDTH-1:0]    pwdata,
   output logic [ife_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                  pready
);
   import ife_pkg::*;

   logic      accept;
   logic      buf_full;
   logic [4:0] header_length;
   state_type state_ff;
   state_type state_in;
   state_type state_step;
   rsp_type   step_word;

   // configuration register
   ife_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .header_length (header_length)
   );

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // tagging and next-state logic for one character
   ife_step u_step (
      .state_cur     (state_ff),
      .req_word      (req_data),
      .header_length (header_length),
      .state_nxt     (state_step),
      .rsp_word      (step_word)
   );

   // parser state advances only on an accepted character
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = state_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register with one skid entry
   ife_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_word (step_word),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/ife_csr.sv =====
module ife_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ife_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  logic [ife_pkg::CSR_DATA_WIDTH-1:0]    pwdata,
   output logic [ife_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                  pready,
   output logic [4:0]                            header_length
);
   import ife_pkg::*;

   logic [4:0] header_length_ff;
   logic [4:0] header_length_in;
   logic       hit;

   assign hit    = (paddr[2] == REG_HEADER_LENGTH);
   assign pready = 1'b1;

   always_comb begin
      header_length_in = header_length_ff;
      if (psel && penable && pwrite && hit) begin
         header_length_in = pwdata[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_length_ff <= HEADER_LENGTH_RESET;
      end else begin
         header_length_ff <= header_length_in;
      end
   end

   assign prdata        = hit ? {27'd0, header_length_ff} : '0;
   assign header_length = header_length_ff;

endmodule

// ===== hw/rtl/ife_step.sv =====
module ife_step (
   input  ife_pkg::state_type state_cur,
   input  ife_pkg::req_type   req_word,
   input  logic [4:0]         header_length,
   output ife_pkg::state_type state_nxt,
   output ife_pkg::rsp_type   rsp_word
);
   import ife_pkg::*;

   // field number of each slot
   function automatic logic [6:0] slot_field(input logic [SLOT_WIDTH-1:0] s);
      logic [6:0] f;
      case (s)
         4'd0:    f = 7'd3;
         4'd1:    f = 7'd4;
         4'd2:    f = 7'd11;
         4'd3:    f = 7'd12;
         4'd4:    f = 7'd18;
         4'd5:    f = 7'd22;
         4'd6:    f = 7'd24;
         4'd7:    f = 7'd34;
         4'd8:    f = 7'd39;
         4'd9:    f = 7'd41;
         default: f = 7'd0;
      endcase
      return f;
   endfunction

   // characters in each slot's field
   function automatic logic [4:0] slot_len(input logic [SLOT_WIDTH-1:0] s);
      logic [4:0] n;
      case (s)
         4'd0:    n = 5'd6;
         4'd1:    n = 5'd12;
         4'd2:    n = 5'd6;
         4'd3:    n = 5'd12;
         4'd4:    n = 5'd4;
         4'd5:    n = 5'd3;
         4'd6:    n = 5'd4;
         4'd7:    n = 5'd8;
         4'd8:    n = 5'd3;
         4'd9:    n = 5'd8;
         default: n = 5'd0;
      endcase
      return n;
   endfunction

   // bitmap bits of the fixed-length fields (field f sits at bit 64-f)
   function automatic logic [NUM_FIELDS-1:0] field_mask(input logic [63:0] b);
      return {b[23], b[25], b[30], b[40], b[42], b[46], b[52], b[53], b[60], b[61]};
   endfunction

   // {is hex, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else begin
         r = 5'd0;
      end
      return r;
   endfunction

   state_type             cur;
   state_type             nxt;
   rsp_type               res;
   logic [4:0]            hex;
   logic [7:0]            pair_byte;
   logic [5:0]            shamt;
   logic [NUM_FIELDS-1:0] pend;
   logic                  any_pend;
   logic [SLOT_WIDTH-1:0] first_slot;
   logic                  finish;
   logic [4:0]            flen;

   always_comb begin
      cur = state_cur;
      if (req_word.start_of_message) begin
         cur = STATE_RESET;
      end
      if (cur.phase == PH_HEADER && cur.pos == 5'd0 && header_length == 5'd0) begin
         cur.phase = PH_MTI;
      end

      nxt              = cur;
      res              = '0;
      res.section      = cur.phase;
      res.data_char    = req_word.char_in;
      hex              = hex_decode(req_word.char_in);
      pair_byte        = 8'd0;
      shamt            = {~cur.pos[3:1], 3'b000};
      pend             = cur.pending;
      finish           = 1'b0;
      flen             = slot_len(cur.slot);

      case (cur.phase)
         PH_HEADER: begin
            if ({1'b0, cur.pos} + 6'd1 >= {1'b0, header_length}) begin
               res.section_last = 1'b1;
               nxt.phase        = PH_MTI;
               nxt.pos          = 5'd0;
            end else begin
               nxt.pos = cur.pos + 5'd1;
            end
         end
         PH_MTI: begin
            if (cur.pos >= MTI_LAST_POS) begin
               res.section_last = 1'b1;
               nxt.phase        = PH_BITMAP;
               nxt.pos          = 5'd0;
            end else begin
               nxt.pos = cur.pos + 5'd1;
            end
         end
         PH_BITMAP: begin
            res.hex_error = ~hex[4];
            if (!cur.pos[0]) begin
               nxt.high_nibble = hex[4] ? {1'b0, hex[3:0]} : 5'h10;
            end else begin
               if (cur.high_nibble[4]) begin
                  pair_byte = 8'd0;
               end else if (hex[4]) begin
                  pair_byte = {cur.high_nibble[3:0], hex[3:0]};
               end else begin
                  pair_byte = {4'd0, cur.high_nibble[3:0]};
               end
               nxt.bitmap = cur.bitmap | (64'(pair_byte) << shamt);
            end
            if (cur.pos >= BITMAP_LAST_POS) begin
               res.section_last = 1'b1;
               nxt.done         = 1'b1;
               pend             = field_mask(nxt.bitmap);
               finish           = 1'b1;
            end else begin
               nxt.pos = cur.pos + 5'd1;
            end
         end
         PH_FIELD: begin
            res.field_number = slot_field(cur.slot);
            if ({1'b0, cur.pos} + 6'd1 >= {1'b0, flen}) begin
               res.section_last = 1'b1;
               for (int k = 0; k < NUM_FIELDS; k++) begin
                  if (SLOT_WIDTH'(k) == cur.slot) begin
                     pend[k] = 1'b0;
                  end
               end
               finish = 1'b1;
            end else begin
               nxt.pos = cur.pos + 5'd1;
            end
         end
         default: begin
            res.section = PH_TRAIL;
            nxt.phase   = PH_TRAIL;
            nxt.slot    = '0;
            nxt.pos     = 5'd0;
         end
      endcase

      // priority pick of the lowest pending field
      any_pend   = |pend;
      first_slot = '0;
      for (int k = NUM_FIELDS - 1; k >= 0; k--) begin
         if (pend[k]) begin
            first_slot = SLOT_WIDTH'(k);
         end
      end

      if (finish) begin
         nxt.pending = pend;
         nxt.slot    = first_slot;
         nxt.pos     = 5'd0;
         nxt.phase   = any_pend ? PH_FIELD : PH_TRAIL;
      end

      res.bitmap_value = nxt.bitmap;
      res.bitmap_valid = nxt.done;
   end

   assign state_nxt = nxt;
   assign rsp_word  = res;

endmodule

// ===== hw/rtl/ife_outbuf.sv =====
module ife_outbuf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ife_pkg::rsp_type push_word,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ife_pkg::rsp_type rsp_data
);
   import ife_pkg::*;

   logic    main_valid_ff;
   logic    main_valid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type main_ff;
   rsp_type main_in;
   rsp_type skid_ff;
   rsp_type skid_in;
   logic    take;

   assign take = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_in       = push_word;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_word;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule

// ===== sim/iso8583_field_extractor_check.sv =====
`timescale 1ns / 1ps

module iso8583_field_extractor_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  ife_pkg::req_type                    req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  ife_pkg::rsp_type                    rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ife_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [ife_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   input  logic                                pready,
   output int                                  tag_failures,
   output int                                  tags_outstanding,
   output int                                  tags_checked
);
   import ife_pkg::*;

   localparam int unsigned MTI_CHARS    = 4;
   localparam int unsigned BITMAP_CHARS = 16;
   localparam int          REPORT_LIMIT = 10;
   localparam logic [CSR_ADDR_WIDTH-1:0] HEADER_ADDR =
      CSR_ADDR_WIDTH'(4 * REG_HEADER_LENGTH);

   logic [4:0]  header_len;
   phase_type   parse_phase;
   int unsigned parse_pos;
   logic [63:0] fields_left;
   logic [63:0] bitmap_acc;
   logic [4:0]  nibble_hold;
   int unsigned element_now;
   logic        bitmap_seen;
   rsp_type     expected_tags[$];
   int          reported;

   function automatic int unsigned element_length(int unsigned num);
      case (num)
         3, 11:   return 6;
         4, 12:   return 12;
         18, 24:  return 4;
         22, 39:  return 3;
         34, 41:  return 8;
         default: return 0;
      endcase
   endfunction

   // bit 4 set: not a hex digit
   function automatic logic [4:0] hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
      if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
      return 5'b10000;
   endfunction

   function automatic void clear_parse();
      parse_phase = PH_HEADER;
      parse_pos   = 0;
      fields_left = '0;
      bitmap_acc  = '0;
      nibble_hold = '0;
      element_now = 0;
      bitmap_seen = 1'b0;
   endfunction

   // lowest pending element, field 1 sits in bit 63
   function automatic void enter_fields();
      element_now = 0;
      for (int num = 1; num <= 64 && element_now == 0; num++)
         if (fields_left[64 - num]) element_now = num;
      parse_pos   = 0;
      parse_phase = (element_now != 0) ? PH_FIELD : PH_TRAIL;
   endfunction

   function automatic rsp_type tag_char(req_type w);
      rsp_type     t;
      logic [4:0]  nib;
      logic [7:0]  pair;
      logic [63:0] mask;
      int unsigned num;
      t = '0;
      t.data_char = w.char_in;
      if (w.start_of_message) clear_parse();
      if (parse_phase == PH_HEADER && parse_pos == 0 && header_len == 0)
         parse_phase = PH_MTI;
      t.section = parse_phase;
      case (parse_phase)
         PH_HEADER: begin
            if (parse_pos + 1 >= header_len) begin
               t.section_last = 1'b1;
               parse_phase = PH_MTI;
               parse_pos = 0;
            end else begin
               parse_pos++;
            end
         end
         PH_MTI: begin
            if (parse_pos + 1 >= MTI_CHARS) begin
               t.section_last = 1'b1;
               parse_phase = PH_BITMAP;
               parse_pos = 0;
            end else begin
               parse_pos++;
            end
         end
         PH_BITMAP: begin
            nib = hex_nibble(w.char_in);
            t.hex_error = nib[4];
            if (parse_pos[0] == 1'b0) begin
               nibble_hold = nib;
            end else begin
               if (nibble_hold[4])  pair = 8'h00;
               else if (!nib[4])    pair = {nibble_hold[3:0], nib[3:0]};
               else                 pair = {4'h0, nibble_hold[3:0]};
               bitmap_acc |= {56'd0, pair} << (8 * (7 - (parse_pos >> 1)));
            end
            if (parse_pos + 1 >= BITMAP_CHARS) begin
               t.section_last = 1'b1;
               bitmap_seen = 1'b1;
               mask = '0;
               for (num = 1; num <= 64; num++)
                  if (element_length(num) != 0) mask[64 - num] = 1'b1;
               fields_left = bitmap_acc & mask;
               enter_fields();
            end else begin
               parse_pos++;
            end
         end
         PH_FIELD: begin
            num = element_now;
            t.field_number = 7'(num);
            if (num == 0 || parse_pos + 1 >= element_length(num)) begin
               t.section_last = 1'b1;
               if (num != 0) fields_left[64 - num] = 1'b0;
               enter_fields();
            end else begin
               parse_pos++;
            end
         end
         default: begin
            t.section   = PH_TRAIL;
            parse_phase = PH_TRAIL;
            element_now = 0;
            parse_pos   = 0;
         end
      endcase
      t.bitmap_value = bitmap_acc;
      t.bitmap_valid = bitmap_seen;
      return t;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         header_len = HEADER_LENGTH_RESET;
         clear_parse();
         expected_tags.delete();
         tag_failures = 0;
         tags_checked = 0;
         reported = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == HEADER_ADDR)
            header_len = pwdata[4:0];
         if (req_valid && !req_stall) expected_tags.push_back(tag_char(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_tags.size() == 0) begin
               tag_failures++;
               if (reported < REPORT_LIMIT)
                  $display("unexpected tag word: section %0d field %0d char %02h",
                           rsp_data.section, rsp_data.field_number, rsp_data.data_char);
               reported++;
            end else begin
               want = expected_tags.pop_front();
               tags_checked++;
               if (rsp_data.section      !== want.section      ||
                   rsp_data.field_number !== want.field_number ||
                   rsp_data.data_char    !== want.data_char    ||
                   rsp_data.section_last !== want.section_last ||
                   rsp_data.bitmap_value !== want.bitmap_value ||
                   rsp_data.bitmap_valid !== want.bitmap_valid ||
                   rsp_data.hex_error    !== want.hex_error) begin
                  tag_failures++;
                  if (reported < REPORT_LIMIT) begin
                     $display("tag mismatch on word %0d", tags_checked);
                     $display("  expected: sect %0d fld %0d chr %02h last %0b map %016h %0b err %0b",
                              want.section, want.field_number, want.data_char,
                              want.section_last, want.bitmap_value, want.bitmap_valid,
                              want.hex_error);
                     $display("  actual:   sect %0d fld %0d chr %02h last %0b map %016h %0b err %0b",
                              rsp_data.section, rsp_data.field_number, rsp_data.data_char,
                              rsp_data.section_last, rsp_data.bitmap_value,
                              rsp_data.bitmap_valid, rsp_data.hex_error);
                  end
                  reported++;
               end
            end
         end
      end
      tags_outstanding = expected_tags.size();
   end

endmodule

// ===== sim/iso8583_field_extractor_test.sv =====
`timescale 1ns / 1ps

module iso8583_field_extractor_test;
   import ife_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 150;
   localparam int PHASE_WORDS = 240;
   localparam int NUM_PHASES  = 6;
   // header_length, plus the next word address which maps to nothing
   localparam logic [CSR_ADDR_WIDTH-1:0] HEADER_ADDR =
      CSR_ADDR_WIDTH'(4 * REG_HEADER_LENGTH);
   localparam logic [CSR_ADDR_WIDTH-1:0] SPARE_ADDR =
      CSR_ADDR_WIDTH'(4 * (REG_HEADER_LENGTH + 1));

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   // idling knobs, in percent of cycles
   int   idle_pct = 0;
   int   stall_pct = 0;
   // long hold-offs asked for by the sender, served by the receiver
   int   long_holds_asked = 0;

   int words_sent = 0;
   int messages_sent = 0;
   int cur_header_len = 12;
   int cycle_count = 0;

   int tag_failures;
   int tags_outstanding;
   int tags_checked;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   iso8583_field_extractor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // predicts every tag word and compares what comes out
   iso8583_field_extractor_check u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .tag_failures     (tag_failures),
      .tags_outstanding (tags_outstanding),
      .tags_checked     (tags_checked)
   );

   // watchdog: a hung handshake ends the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d tags outstanding",
                  cycle_count, tags_outstanding);
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver side: random stall, or a long hold-off counted out here
   initial begin : receiver
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (long_holds_asked != holds_served) begin
            holds_served = long_holds_asked;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // offer one character word, starting and ending at a falling edge
   task automatic send_word(input logic [7:0] c, input logic som);
      req_type w;
      w.char_in = c;
      w.start_of_message = som;
      // random gaps before the word, valid drops only while idling
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      // hold the word until an edge with no stall
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   // sender goes quiet until every tag word has come back
   task automatic drain_tags();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tags_outstanding != 0) @(negedge clock);
   endtask

   // setup cycle then access cycle, write lands when pready is seen
   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] a,
                            input logic [CSR_DATA_WIDTH-1:0] d);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= a;
      pwdata  <= d;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // a message of the current header length with a random bitmap and body
   task automatic send_message();
      logic [63:0] map;
      logic [7:0]  chars[$];
      logic [3:0]  nib;
      int          k;
      case ($urandom_range(7))
         0:       map = '0;
         1:       map = '1;
         default: map = {$urandom, $urandom};
      endcase
      repeat (cur_header_len) chars.push_back(8'($urandom_range(255)));
      repeat (4) chars.push_back(8'("0" + $urandom_range(9)));
      // bitmap digits in either case, now and then a damaged one
      for (k = 15; k >= 0; k--) begin
         nib = map[4*k +: 4];
         if ($urandom_range(99) < 6)   chars.push_back(8'($urandom_range(255)));
         else if (nib < 10)            chars.push_back(8'("0" + nib));
         else if ($urandom_range(1))   chars.push_back(8'("a" + nib - 10));
         else                          chars.push_back(8'("A" + nib - 10));
      end
      // element data, running short of or past the fixed fields
      repeat ($urandom_range(60)) chars.push_back(8'($urandom_range(255)));
      // broken message: cut short, the next start mark takes over
      if ($urandom_range(99) < 12) begin
         k = $urandom_range(chars.size() - 1, 1);
         chars = chars[0:k-1];
      end
      foreach (chars[i]) send_word(chars[i], i == 0);
      messages_sent++;
   endtask

   initial begin : stimulus
      logic [7:0] directed[$];
      int         tx_plan[NUM_PHASES];
      int         rx_plan[NUM_PHASES];
      int         hl_plan[NUM_PHASES];
      int         p;
      int         phase_end;
      tx_plan = '{0, 63, 0, 19, 63, 0};
      rx_plan = '{0, 0, 63, 19, 0, 63};
      hl_plan = '{12, 0, 31, 1, 0, 0};

      // synchronous reset, released at a falling edge
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // no start mark after reset: header of the default length begins here
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      repeat (3) send_word(8'($urandom_range(255)), 1'b0);

      // shrink the header mid-way, the next word closes it
      // the unmapped address must not touch header_length
      drain_tags();
      csr_write(HEADER_ADDR, 3);
      csr_write(SPARE_ADDR, 31);
      cur_header_len = 3;

      // mti then a bitmap with bad first digit, bad second digit, extreme
      // bytes and mixed case; no fixed field is set so a trailing word follows
      directed = '{8'h41, "0", "2", "0", "0",
                   "c", "0", "g", "1", "8", "z", 8'hFF, "5",
                   "0", 8'h00, "0", "0", "a", "B", "F", "f", 8'h7E};
      foreach (directed[i]) send_word(directed[i], 1'b0);

      // zero header: the first marked word is already mti
      drain_tags();
      csr_write(HEADER_ADDR, 0);
      cur_header_len = 0;
      send_word("9", 1'b1);
      send_word("1", 1'b0);

      // random phases over header lengths and idling mixes
      for (p = 0; p < NUM_PHASES; p++) begin
         drain_tags();
         cur_header_len = (p < 4) ? hl_plan[p] : $urandom_range(31);
         csr_write(HEADER_ADDR, CSR_DATA_WIDTH'(cur_header_len));
         idle_pct  = tx_plan[p];
         stall_pct = rx_plan[p];
         // full-rate sender against a blocked receiver: the block fills and
         // pushes back on req
         if (p == 0) long_holds_asked++;
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) begin
            if ($urandom_range(99) < 85) begin
               send_message();
            end else begin
               // noise with stray start marks
               repeat ($urandom_range(12, 1))
                  send_word(8'($urandom_range(255)), $urandom_range(99) < 10);
            end
         end
      end

      // let the last tags out, then a few quiet cycles
      drain_tags();
      repeat (8) @(posedge clock);

      $display("covered %0d tag words from %0d messages plus noise, header lengths 0 to 31",
               tags_checked, messages_sent);
      $display("with bursts, sender gaps, receiver stalls and a long hold-off; %0d mismatches",
               tag_failures);
      if (tag_failures == 0 && tags_outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
